[rtl/lu_linear_system_solver_core_defines.svh]
// assertion macros for the lu solver checker
// no dependencies; expects clk and rst_n in the scope of use
`ifndef LU_LINEAR_SYSTEM_SOLVER_CORE_DEFINES_SVH
`define LU_LINEAR_SYSTEM_SOLVER_CORE_DEFINES_SVH

// same-cycle implication
`define LUSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("luss check failed");

// next-cycle implication
`define LUSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("luss check failed");

`endif

[rtl/luss_pkg.sv]
// shared types, codes and fixed-point helpers of the lu solver
// no dependencies
package luss_pkg;

    localparam int MAX_SIZE_DEF = 8;
    localparam logic [3:0] SIZE_RESET = 4'd8;
    localparam int DIV_BITS = 48;

    typedef struct packed {
        logic [2:0]        row;
        logic [3:0]        col;
        logic signed [31:0] value;
        logic              last;
    } in_word_t;

    typedef struct packed {
        logic [2:0]        index;
        logic signed [31:0] solution;
        logic              zero_pivot;
        logic              final_res;
    } out_word_t;

    typedef enum logic [3:0] {
        S_IDLE, S_JOB, S_PIV, S_LOAD, S_RDA, S_RDB, S_MUL, S_ACC,
        S_FIN, S_DIV, S_DWR, S_NEXT, S_ORD, S_OLAT, S_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_U, PH_L, PH_F, PH_B
    } phase_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000)
            r = -32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // round q32.32 product to q16.16, floor after adding half
    function automatic logic signed [63:0] qround(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd32768;
        return t >>> 16;
    endfunction

endpackage

[rtl/lu_linear_system_solver_core.sv]
// lu solver top level: load store, doolittle factorisation, substitutions
// depends on luss_pkg
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+------------------------------
//  in      | in  | in_valid/in_ready  | row, col, value, last
//  out     | out | out_valid/out_ready| index, solution, zero_pivot, final_res
//  cfg     | in  | cfg_we             | matrix_size (4 bits)
//
// load words are written while idle. after a last word the solve runs on one
// multiplier and one radix-2 divider: a multiply-accumulate steps through
// S_RDA, S_RDB, S_MUL, S_ACC (single read port, two reads a term), a divide
// through S_DIV and S_DWR, a result through S_ORD, S_OLAT and a stallable S_OUT.
// in_ready is low from a last word until the final result is taken.
// async active-low reset; the store itself is not cleared.
module lu_linear_system_solver_core #(
    parameter int MAX_SIZE = luss_pkg::MAX_SIZE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  luss_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output luss_pkg::out_word_t out_data,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_wdata
);
    import luss_pkg::*;

    // each row holds the matrix, the rhs and a scratch word for y and x
    localparam int DEPTH = MAX_SIZE * (MAX_SIZE + 2);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(MAX_SIZE + 2);
    localparam int CAP = (MAX_SIZE < 8) ? MAX_SIZE : 8;
    localparam logic [CW-1:0] RC = CW'(MAX_SIZE);
    localparam logic [CW-1:0] YC = CW'(MAX_SIZE + 1);
    localparam int DCW = $clog2(DIV_BITS);

    logic [31:0] mem [DEPTH];
    logic signed [31:0] rdata_reg;
    logic mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0] mem_wdata;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [3:0] size_reg, size_next;
    logic [3:0] i_reg, i_next, k_reg, k_next, j_reg, j_next;
    logic signed [63:0] acc_reg, acc_next, prod_reg, prod_next;
    logic signed [31:0] opa_reg, opa_next, piv_reg, piv_next;
    logic [31:0] rem_reg, rem_next;
    logic [DIV_BITS-1:0] quo_reg, quo_next;
    logic [DCW-1:0] dcnt_reg, dcnt_next;
    logic dneg_reg, dneg_next;
    logic err_reg, err_next;
    logic ov_reg, ov_next;
    out_word_t od_reg, od_next;

    logic [3:0] n;
    logic [3:0] ra, jlo, jhi;
    logic [CW-1:0] cb, cy;
    logic dv;
    logic signed [31:0] s;
    logic [31:0] smag, dmag;
    logic [32:0] t;
    logic [DIV_BITS:0] q;
    logic [63:0] qx;
    logic rup;

    function automatic logic [AW-1:0] addr_of(input logic [3:0] r, input logic [CW-1:0] c);
        return AW'(r * (MAX_SIZE + 2)) + AW'(c);
    endfunction

    // active system size
    always_comb
    begin
        n = (size_reg == 4'd0) ? 4'd1 : size_reg;
        if (n > 4'(CAP))
            n = 4'(CAP);
    end

    // operands of the current dot-product job
    // cb: column of the starting term, cy: column of the result and right operand
    always_comb
    begin
        ra = i_reg; cb = RC; cy = YC; jlo = 4'd0; jhi = i_reg; dv = 1'b0;
        case (phase_reg)
            PH_U:
            begin
                cb = CW'(k_reg); cy = CW'(k_reg);
            end
            PH_L:
            begin
                ra = k_reg; cb = CW'(i_reg); cy = CW'(i_reg); dv = 1'b1;
            end
            PH_F:
            begin
                cb = RC; cy = YC;
            end
            PH_B:
            begin
                cb = YC; cy = YC;
                jlo = i_reg + 4'd1; jhi = n; dv = 1'b1;
            end
            default:
            begin
                cb = RC; cy = YC;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        s = sat32(acc_reg);
        smag = s[31] ? 32'(-s) : 32'(s);
        dmag = piv_reg[31] ? 32'(-piv_reg) : 32'(piv_reg);
        t = {rem_reg, quo_reg[DIV_BITS-1]};
        rup = ({rem_reg, 1'b0} >= {1'b0, dmag});
        q = {1'b0, quo_reg} + (DIV_BITS+1)'(rup);
        qx = dneg_reg ? 64'(-{{(63-DIV_BITS){1'b0}}, q}) : {{(63-DIV_BITS){1'b0}}, q};
    end

    always_comb
    begin
        state_next = state_reg; phase_next = phase_reg; size_next = size_reg;
        i_next = i_reg; k_next = k_reg; j_next = j_reg;
        acc_next = acc_reg; prod_next = prod_reg; opa_next = opa_reg; piv_next = piv_reg;
        rem_next = rem_reg; quo_next = quo_reg; dcnt_next = dcnt_reg; dneg_next = dneg_reg;
        err_next = err_reg; ov_next = ov_reg; od_next = od_reg;
        mem_we = 1'b0; mem_waddr = addr_of(ra, cy); mem_wdata = s;
        mem_raddr = addr_of(ra, cb);
        in_ready = (state_reg == S_IDLE);
        if (cfg_we)
            size_next = cfg_wdata;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if ({1'b0, in_data.row} < n && in_data.col <= n)
                    begin
                        mem_we = 1'b1;
                        mem_waddr = addr_of({1'b0, in_data.row},
                            (in_data.col == n) ? RC : CW'(in_data.col));
                        mem_wdata = in_data.value;
                    end
                    if (in_data.last)
                    begin
                        err_next = 1'b0; phase_next = PH_U;
                        i_next = 4'd0; k_next = 4'd0;
                        state_next = S_JOB;
                    end
                end
            end
            S_JOB:
            begin
                j_next = jlo;
                if (dv)
                begin
                    mem_raddr = addr_of(i_reg, CW'(i_reg));
                    state_next = S_PIV;
                end
                else
                    state_next = S_LOAD;
            end
            S_PIV:
            begin
                piv_next = rdata_reg;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                acc_next = 64'(rdata_reg);
                state_next = (j_reg < jhi) ? S_RDA : S_FIN;
            end
            S_RDA:
            begin
                mem_raddr = addr_of(ra, CW'(j_reg));
                state_next = S_RDB;
            end
            S_RDB:
            begin
                opa_next = rdata_reg;
                mem_raddr = addr_of(j_reg, cy);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next = $signed({{32{opa_reg[31]}}, opa_reg})
                          * $signed({{32{rdata_reg[31]}}, rdata_reg});
                state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next = acc_reg - qround(prod_reg);
                j_next = j_reg + 4'd1;
                state_next = (j_reg + 4'd1 < jhi) ? S_RDA : S_FIN;
            end
            S_FIN:
            begin
                if (!dv)
                begin
                    mem_we = 1'b1;
                    if (phase_reg == PH_U && k_reg == i_reg && s == 32'sd0)
                        err_next = 1'b1;
                    state_next = S_NEXT;
                end
                else if (piv_reg == 32'sd0)
                begin
                    // division by zero gives zero
                    mem_we = 1'b1; mem_wdata = 32'd0;
                    state_next = S_NEXT;
                end
                else
                begin
                    dneg_next = s[31] ^ piv_reg[31];
                    quo_next = {smag, 16'd0};
                    rem_next = 32'd0; dcnt_next = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (t >= {1'b0, dmag})
                begin
                    rem_next = 32'(t - {1'b0, dmag});
                    quo_next = {quo_reg[DIV_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = t[31:0];
                    quo_next = {quo_reg[DIV_BITS-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + DCW'(1);
                if (dcnt_reg == DCW'(DIV_BITS - 1))
                    state_next = S_DWR;
            end
            S_DWR:
            begin
                // round half away from zero, then saturate
                mem_we = 1'b1; mem_wdata = sat32($signed(qx));
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                state_next = S_JOB;
                case (phase_reg)
                    PH_U:
                    begin
                        if (k_reg + 4'd1 < n)
                            k_next = k_reg + 4'd1;
                        else if (i_reg + 4'd1 < n)
                        begin
                            phase_next = PH_L; k_next = i_reg + 4'd1;
                        end
                        else
                        begin
                            phase_next = PH_F; i_next = 4'd0;
                        end
                    end
                    PH_L:
                    begin
                        if (k_reg + 4'd1 < n)
                            k_next = k_reg + 4'd1;
                        else
                        begin
                            phase_next = PH_U; i_next = i_reg + 4'd1; k_next = i_reg + 4'd1;
                        end
                    end
                    PH_F:
                    begin
                        if (i_reg + 4'd1 < n)
                            i_next = i_reg + 4'd1;
                        else
                        begin
                            phase_next = PH_B; i_next = n - 4'd1;
                        end
                    end
                    default:
                    begin
                        if (i_reg != 4'd0)
                            i_next = i_reg - 4'd1;
                        else
                            state_next = S_ORD;
                    end
                endcase
            end
            S_ORD:
            begin
                mem_raddr = addr_of(i_reg, YC);
                state_next = S_OLAT;
            end
            S_OLAT:
            begin
                od_next.index = i_reg[2:0];
                od_next.solution = rdata_reg;
                od_next.zero_pivot = err_reg;
                od_next.final_res = (i_reg + 4'd1 == n);
                ov_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    ov_next = 1'b0;
                    if (i_reg + 4'd1 < n)
                    begin
                        i_next = i_reg + 4'd1; state_next = S_ORD;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_U;
            size_reg <= SIZE_RESET;
            err_reg <= 1'b0;
            ov_reg <= 1'b0;
            i_reg <= 4'd0;
            k_reg <= 4'd0;
            j_reg <= 4'd0;
            dcnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            size_reg <= size_next;
            err_reg <= err_next;
            ov_reg <= ov_next;
            i_reg <= i_next;
            k_reg <= k_next;
            j_reg <= j_next;
            dcnt_reg <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        prod_reg <= prod_next;
        opa_reg <= opa_next;
        piv_reg <= piv_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dneg_reg <= dneg_next;
        od_reg <= od_next;
    end

    assign out_valid = ov_reg;
    assign out_data = od_reg;

endmodule

[rtl/luss_checker.sv]
// port-level checks for the lu solver, bound to the top level
// depends on luss_pkg and the defines header
`include "lu_linear_system_solver_core_defines.svh"

module luss_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input luss_pkg::in_word_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input luss_pkg::out_word_t out_data
);
    import luss_pkg::*;

    // a stalled result word holds
    `LUSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    // no loading while results are pending
    `LUSS_ASSERT_NOW(a_busy_out, out_valid, !in_ready)
    // a last word starts the solve
    `LUSS_ASSERT_NEXT(a_last_busy, in_valid && in_ready && in_data.last, !in_ready)
    // nothing follows the final result
    `LUSS_ASSERT_NEXT(a_final_end, out_valid && out_ready && out_data.final_res, !out_valid)

endmodule

bind lu_linear_system_solver_core luss_checker u_luss_checker (.*);
